[rtl/pli_pkg.sv]
// Shared types and constants of the piecewise linear interpolator.
`timescale 1ns / 1ps
`default_nettype none
package pli_pkg;

  localparam int XW          = 32;   // Q16.16 word
  localparam int PC_W        = 7;    // point count register
  localparam int IDX_IN_W    = 6;    // point_index field
  localparam int ST_W        = 2;    // status field
  localparam int IN_TDATA_W  = 72;   // 6 + 32 + 32, padded to whole bytes
  localparam int OUT_TDATA_W = 32;
  localparam int PROD_W      = 64;
  localparam int DIV_STEPS   = 64;   // one quotient bit per step
  localparam int DIVC_W      = 6;

  // status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_LOADED = 2'd1;
  localparam logic [ST_W-1:0] ST_SAT    = 2'd2;
  localparam logic [ST_W-1:0] ST_ZSPAN  = 2'd3;

  // table address select
  localparam logic [1:0] ADDR_IN   = 2'd0;
  localparam logic [1:0] ADDR_HI   = 2'd1;
  localparam logic [1:0] ADDR_NEXT = 2'd2;
  localparam logic [1:0] ADDR_LO   = 2'd3;

  typedef struct packed {
    logic       load_wr;
    logic       start;
    logic [1:0] addr_sel;
    logic       scan_step;
    logic       cap_lo;
    logic       cap_diff;
    logic       mul;
    logic       div_step;
    logic       res_load;
    logic       res_zspan;
    logic       res_calc;
    logic       post;
  } pli_cmd_t;

  typedef struct packed {
    logic n_is_two;
    logic x_gt;
    logic at_end;
    logic zero_span;
    logic div_last;
  } pli_sts_t;

endpackage
`default_nettype wire

[rtl/pli_ram.sv]
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module pli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

[rtl/pli_dp.sv]
// Datapath: breakpoint tables, scan counter, multiplier, divider, result regs.
`timescale 1ns / 1ps
`default_nettype none
module pli_dp #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  input  wire logic [pli_pkg::PC_W-1:0]         cfg_data,
  input  wire logic [pli_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire pli_pkg::pli_cmd_t                cmd,
  output pli_pkg::pli_sts_t                     sts,
  output logic      [pli_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic      [pli_pkg::ST_W-1:0]         out_tuser
);
  import pli_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  logic [PC_W-1:0]        pc_r;
  logic [CNT_W-1:0]       n_eff;
  logic [IDX_W-1:0]       nm1;
  logic [IDX_IN_W-1:0]    in_idx;
  logic [XW-1:0]          in_x, in_y;
  logic                   idx_ok, ram_we;
  logic [IDX_W-1:0]       addr;
  logic [XW-1:0]          x_rd, y_rd;

  logic signed [XW-1:0]   q_r, xlo_r, ylo_r;
  logic [IDX_W-1:0]       hi_r;
  logic [XW-1:0]          mdq_r, mdy_r, div_r;
  logic                   neg_r;
  logic [PROD_W-1:0]      quo_r;
  logic [XW-1:0]          rem_r;
  logic [DIVC_W-1:0]      cnt_r;
  logic [XW-1:0]          res_r, res_calc;
  logic [ST_W-1:0]        st_r, st_calc;
  logic [XW-1:0]          out_data_r;
  logic [ST_W-1:0]        out_user_r;

  logic [XW:0]            dx, dq, dy;
  logic [PROD_W-1:0]      prod;
  logic [XW:0]            shifted;
  logic [XW+1:0]          trial;
  logic                   ge;
  logic                   big, negq;
  logic signed [XW+2:0]   sum;

  function automatic logic [XW-1:0] mag33(input logic [XW:0] d);
    logic [XW:0] n;
    n = d[XW] ? (~d + 1'b1) : d;
    return n[XW-1:0];
  endfunction

  assign in_idx = in_tdata[IDX_IN_W-1:0];
  assign in_x   = in_tdata[IDX_IN_W+XW-1:IDX_IN_W];
  assign in_y   = in_tdata[IDX_IN_W+2*XW-1:IDX_IN_W+XW];

  // effective count, clamped to 2 .. MAX_POINTS (the table depth)
  always_comb begin
    if (int'(pc_r) > MAX_POINTS) begin
      n_eff = CNT_W'(MAX_POINTS);
    end else if (pc_r < PC_W'(2)) begin
      n_eff = CNT_W'(2);
    end else begin
      n_eff = CNT_W'(pc_r);
    end
  end
  assign nm1 = IDX_W'(n_eff - 1'b1);

  assign idx_ok = int'(in_idx) < MAX_POINTS;
  assign ram_we = cmd.load_wr && idx_ok;

  always_comb begin
    case (cmd.addr_sel)
      ADDR_IN:   addr = IDX_W'(in_idx);
      ADDR_HI:   addr = hi_r;
      ADDR_NEXT: addr = hi_r + 1'b1;
      ADDR_LO:   addr = hi_r - 1'b1;
      default:   addr = hi_r;
    endcase
  end

  pli_ram #(.WIDTH(XW), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk(clk), .we(ram_we), .addr(addr), .wdata(in_x), .rdata(x_rd)
  );

  pli_ram #(.WIDTH(XW), .DEPTH(MAX_POINTS)) u_y_ram (
    .clk(clk), .we(ram_we), .addr(addr), .wdata(in_y), .rdata(y_rd)
  );

  // segment differences, read data is the upper breakpoint
  assign dx = {x_rd[XW-1], x_rd} - {xlo_r[XW-1], xlo_r};
  assign dq = {q_r[XW-1], q_r}   - {xlo_r[XW-1], xlo_r};
  assign dy = {y_rd[XW-1], y_rd} - {ylo_r[XW-1], ylo_r};

  assign prod = mdq_r * mdy_r;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem_r, quo_r[PROD_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, div_r};
  assign ge      = !trial[XW+1];

  // final sum and saturation
  assign big  = |quo_r[PROD_W-1:XW+1];
  assign negq = neg_r && (quo_r != '0);
  assign sum  = negq ? ($signed({{3{ylo_r[XW-1]}}, ylo_r}) - $signed({1'b0, quo_r[XW+1:0]}))
                     : ($signed({{3{ylo_r[XW-1]}}, ylo_r}) + $signed({1'b0, quo_r[XW+1:0]}));

  always_comb begin
    if (big) begin
      res_calc = negq ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
      st_calc  = ST_SAT;
    end else if (sum[XW+2:XW-1] != {4{sum[XW+2]}}) begin
      res_calc = sum[XW+2] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
      st_calc  = ST_SAT;
    end else begin
      res_calc = sum[XW-1:0];
      st_calc  = ST_OK;
    end
  end

  assign sts.n_is_two  = (n_eff == CNT_W'(2));
  assign sts.x_gt      = $signed(x_rd) > q_r;
  assign sts.at_end    = (hi_r == nm1 - 1'b1);
  assign sts.zero_span = (x_rd == xlo_r);
  assign sts.div_last  = (cnt_r == DIVC_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_W'(2);
    end else if (cfg_valid) begin
      pc_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_r  <= in_x;
      hi_r <= IDX_W'(1);
    end
    if (cmd.scan_step) begin
      hi_r <= hi_r + 1'b1;
    end
    if (cmd.cap_lo) begin
      xlo_r <= x_rd;
      ylo_r <= y_rd;
    end
    if (cmd.cap_diff) begin
      mdq_r <= mag33(dq);
      mdy_r <= mag33(dy);
      div_r <= mag33(dx);
      neg_r <= (dq[XW] ^ dy[XW]) ^ dx[XW];
    end
    if (cmd.mul) begin
      quo_r <= prod;
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= ge ? trial[XW-1:0] : shifted[XW-1:0];
      quo_r <= {quo_r[PROD_W-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.res_load) begin
      res_r <= '0;
      st_r  <= ST_LOADED;
    end
    if (cmd.res_zspan) begin
      res_r <= ylo_r;
      st_r  <= ST_ZSPAN;
    end
    if (cmd.res_calc) begin
      res_r <= res_calc;
      st_r  <= st_calc;
    end
    if (cmd.post) begin
      out_data_r <= res_r;
      out_user_r <= st_r;
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

endmodule
`default_nettype wire

[rtl/pli_ctrl.sv]
// Controller: sequences load, scan, divide and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module pli_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire logic              in_req,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output pli_pkg::pli_cmd_t      cmd,
  input  wire pli_pkg::pli_sts_t sts
);
  import pli_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CMP = 4'd2;
  localparam logic [3:0] S_RD_LO    = 4'd3;
  localparam logic [3:0] S_RD_HI    = 4'd4;
  localparam logic [3:0] S_DIFF     = 4'd5;
  localparam logic [3:0] S_MUL      = 4'd6;
  localparam logic [3:0] S_DIV      = 4'd7;
  localparam logic [3:0] S_FIN      = 4'd8;
  localparam logic [3:0] S_POST     = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_acc, out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.addr_sel  = ADDR_HI;
    case (state_r)
      S_IDLE: begin
        cmd.addr_sel = ADDR_IN;
        if (in_acc) begin
          if (!in_req) begin
            cmd.load_wr  = 1'b1;
            cmd.res_load = 1'b1;
            state_nxt    = S_POST;
          end else begin
            cmd.start = 1'b1;
            state_nxt = sts.n_is_two ? S_RD_LO : S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        // next entry is read ahead while this one is compared
        cmd.addr_sel = ADDR_NEXT;
        if (sts.x_gt) begin
          state_nxt = S_RD_LO;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.at_end) begin
            state_nxt = S_RD_LO;
          end
        end
      end
      S_RD_LO: begin
        cmd.addr_sel = ADDR_LO;
        state_nxt    = S_RD_HI;
      end
      S_RD_HI: begin
        cmd.cap_lo = 1'b1;
        state_nxt  = S_DIFF;
      end
      S_DIFF: begin
        if (sts.zero_span) begin
          cmd.res_zspan = 1'b1;
          state_nxt     = S_POST;
        end else begin
          cmd.cap_diff = 1'b1;
          state_nxt    = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.res_calc = 1'b1;
        state_nxt    = S_POST;
      end
      S_POST: begin
        if (out_free) begin
          cmd.post      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_to_post: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_req) |=> (state_r == S_POST))
    else $error("load beat did not go straight to result hand-off");

  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_req) |=> (state_r == S_SCAN_RD || state_r == S_RD_LO))
    else $error("query beat did not start the scan");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && sts.div_last) |=> (state_r == S_FIN))
    else $error("divider did not finish into result stage");

  a_result_from_post: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == S_POST))
    else $error("result raised outside hand-off state");

  a_post_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POST && out_valid_r && !out_tready) |=> (state_r == S_POST))
    else $error("result overwritten while previous one waits");

endmodule
`default_nettype wire

[rtl/piecewise_linear_interpolator.sv]
// Top level of the piecewise linear interpolator.
//
//  channel | dir | handshake             | payload
//  in      | in  | in_tvalid/in_tready   | tuser: req_type; tdata: point_index, x_value, point_y
//  out     | out | out_tvalid/out_tready | tuser: status;   tdata: interp_y
//  cfg     | in  | cfg_valid/cfg_ready   | cfg_data: point_count
//
// Load beat: table written at the accepting edge, out_tvalid raised from S_POST.
// Query beat: at point_count 2 no scan, else the scan compares 1 .. point_count-2 entries;
//   then come the multiply and the bit-serial divider, and a
//   zero x span skips multiply and divide.
// Reset (rst_n low, synchronous) clears control, point_count to 2; tables undefined.
// in_tready only when idle; a result waiting in the output register stalls the next.
`timescale 1ns / 1ps
`default_nettype none
module piecewise_linear_interpolator #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [5:0] point_index, [37:6] x_value, [69:38] point_y, [71:70] zero
  input  wire logic [pli_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] req_type
  input  wire logic                             in_tuser,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [pli_pkg::PC_W-1:0]         cfg_data,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [31:0] interp_y
  output logic      [pli_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [1:0] status
  output logic      [pli_pkg::ST_W-1:0]         out_tuser
);
  import pli_pkg::*;

  pli_cmd_t cmd;
  pli_sts_t sts;

  assign cfg_ready = 1'b1;

  pli_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_req     (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  pli_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
`default_nettype wire

[test/piecewise_linear_interpolator_tb.sv]
// Self-checking testbench for the piecewise linear interpolator: breakpoint loads and queries.
`timescale 1ns / 1ps
module piecewise_linear_interpolator_tb;
  import pli_pkg::*;

  localparam logic   REQ_LOAD     = 1'b0;
  localparam logic   REQ_QUERY    = 1'b1;
  localparam int     TABLE_DEPTH  = 64;
  localparam int     PHASES       = 10;
  localparam int     PHASE_BEATS  = 193;
  localparam int     CALM_AFTER   = 1750;   // no idling past this many beats
  localparam int     HOLD_AT      = 400;    // results seen before the long sink stall
  localparam int     HOLD_CYCLES  = 300;
  localparam int     DRAIN_CYCLES = 200;
  localparam longint CYCLE_LIMIT  = 1500000;
  localparam longint Q_MAX        = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q_MIN        = -Q_MAX - 1;

  typedef struct packed {
    logic [31:0]     y;
    logic [ST_W-1:0] st;
  } interp_res_t;

  typedef struct packed {
    logic            req;
    logic [5:0]      idx;
    logic [31:0]     xv;
    logic [31:0]     yv;
    logic            typed;   // expected result given in the row
    logic [31:0]     ey;
    logic [ST_W-1:0] est;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [PC_W-1:0]        cfg_data;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [ST_W-1:0]        out_tuser;

  // predictor state
  logic signed [31:0] bp_x [TABLE_DEPTH];
  logic signed [31:0] bp_y [TABLE_DEPTH];
  logic [PC_W-1:0]    count_reg;
  interp_res_t        pending_q [$];

  logic   idle_on;
  logic   hold_long;
  int     beats_sent, results_seen, mismatches, cfg_writes, n_loads, n_queries;
  int     status_seen [4];
  longint cycle_cnt;

  stim_row_t directed [24] = '{
    // two points, steep enough to clip at both ends
    {REQ_LOAD,  6'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_LOADED},
    {REQ_LOAD,  6'd1,  32'h0000_0001, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, ST_LOADED},
    {REQ_QUERY, 6'd0,  32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_SAT},
    {REQ_QUERY, 6'd63, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, ST_SAT},
    {REQ_QUERY, 6'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
    {REQ_QUERY, 6'd0,  32'h0000_0001, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    // equal x at both ends
    {REQ_LOAD,  6'd1,  32'h0000_0000, 32'h0000_1234, 1'b1, 32'h0000_0000, ST_LOADED},
    {REQ_QUERY, 6'd0,  32'h1234_5678, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_ZSPAN},
    // segment spanning the whole range
    {REQ_LOAD,  6'd0,  32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_LOADED},
    {REQ_LOAD,  6'd1,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, ST_LOADED},
    {REQ_QUERY, 6'd0,  32'h8000_0000, 32'h0000_0000, 1'b1, 32'h8000_0000, ST_OK},
    {REQ_QUERY, 6'd0,  32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_OK},
    {REQ_QUERY, 6'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    {REQ_QUERY, 6'd0,  32'hFFFF_0000, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    // x falling from entry 0 to entry 1
    {REQ_LOAD,  6'd0,  32'h000A_0000, 32'h0064_0000, 1'b1, 32'h0000_0000, ST_LOADED},
    {REQ_LOAD,  6'd1,  32'hFFF6_0000, 32'hFF9C_0000, 1'b1, 32'h0000_0000, ST_LOADED},
    {REQ_QUERY, 6'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    {REQ_QUERY, 6'd0,  32'h0014_0000, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    {REQ_QUERY, 6'd0,  32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    // top index, outside the two points in use
    {REQ_LOAD,  6'd63, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0000, ST_LOADED},
    {REQ_LOAD,  6'd0,  32'h0000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_LOADED},
    {REQ_LOAD,  6'd1,  32'h0001_0000, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000, ST_LOADED},
    {REQ_QUERY, 6'd0,  32'h0000_8000, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
    {REQ_QUERY, 6'd0,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK}
  };

  piecewise_linear_interpolator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_q.size());
      $display("piecewise_linear_interpolator: mismatch");
      $finish;
    end
  end

  function automatic int active_points();
    if (count_reg < 2) return 2;
    if (count_reg > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(count_reg);
  endfunction

  // Segment search, exact slope product, truncating divide, 32-bit clamp.
  function automatic interp_res_t interpolate(input logic signed [31:0] q);
    int          n, hi;
    longint      xlo, xhi, ylo, yhi, dx, dq, dy, res;
    logic [63:0] mq, my, mx, quot;
    logic        neg;
    interp_res_t r;
    n  = active_points();
    hi = 1;
    while (hi < n - 1 && bp_x[hi] <= q) hi++;
    xlo = bp_x[hi-1];
    xhi = bp_x[hi];
    ylo = bp_y[hi-1];
    yhi = bp_y[hi];
    dx  = xhi - xlo;
    if (dx == 0) begin
      r.y  = ylo[31:0];
      r.st = ST_ZSPAN;
      return r;
    end
    dq   = longint'(q) - xlo;
    dy   = yhi - ylo;
    neg  = ((dq < 0) != (dy < 0)) != (dx < 0);
    mq   = dq < 0 ? -dq : dq;
    my   = dy < 0 ? -dy : dy;
    mx   = dx < 0 ? -dx : dx;
    quot = (mq * my) / mx;   // magnitudes below 2^32, product fits
    if (quot == 0) neg = 1'b0;
    r.st = ST_OK;
    if (quot >= 64'h2_0000_0000) begin
      r.y  = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      r.st = ST_SAT;
    end else begin
      res = neg ? ylo - longint'(quot) : ylo + longint'(quot);
      if (res > Q_MAX) begin
        res  = Q_MAX;
        r.st = ST_SAT;
      end else if (res < Q_MIN) begin
        res  = Q_MIN;
        r.st = ST_SAT;
      end
      r.y = res[31:0];
    end
    return r;
  endfunction

  function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected %h, got %h (result %0d)", $realtime, what, want, got,
               results_seen);
  endfunction

  // Offer one beat; on acceptance update the predictor and queue the expected result.
  task automatic send_beat(input logic req, input logic [5:0] idx, input logic [31:0] xv,
                           input logic [31:0] yv, input logic typed, input interp_res_t want);
    interp_res_t r;
    if (idle_on && beats_sent < CALM_AFTER && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {2'b00, yv, xv, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (req == REQ_LOAD) begin
      bp_x[idx] = xv;
      bp_y[idx] = yv;
      r.y  = '0;
      r.st = ST_LOADED;
      n_loads++;
    end else begin
      r = interpolate(xv);
      n_queries++;
    end
    if (typed) r = want;
    pending_q = {pending_q, r};
    status_seen[r.st]++;
    beats_sent++;
  endtask

  task automatic set_point_count(input logic [PC_W-1:0] v);
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    count_reg = v;
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  // Fill all 64 entries with rising x; some steps are zero to give flat spans.
  task automatic load_breakpoints();
    int          mode;
    int unsigned step_max;
    longint      xs;
    logic [31:0] yv;
    mode     = $urandom_range(0, 2);
    step_max = mode == 0 ? 32'd1 << 20 : (mode == 1 ? 32'd1 << 25 : 32'd1 << 12);
    xs       = -longint'($urandom_range(0, 32)) * longint'(step_max);
    yv       = $urandom;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if ($urandom_range(0, 9) != 0) xs += $urandom_range(1, step_max);
      yv = mode == 1 ? $urandom : yv + $urandom_range(0, 1 << 23) - (1 << 22);
      send_beat(REQ_LOAD, 6'(i), xs[31:0], yv, 1'b0, '0);
    end
  endtask

  initial begin : result_sink
    int          gap;
    interp_res_t want;
    gap        = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (pending_q.size() == 0) begin
          flag_mismatch("unexpected result beat", '0, out_tdata);
        end else begin
          want = pending_q.pop_front();
          if (out_tdata !== want.y) flag_mismatch("interp_y", want.y, out_tdata);
          if (out_tuser !== want.st) flag_mismatch("status", 32'(want.st), 32'(out_tuser));
        end
      end
      if (hold_long) begin
        out_tready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_tready <= 1'b0;
      end else if (idle_on && beats_sent < CALM_AFTER && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 13) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // one long sink stall so the output register fills and in_tready drops
  initial begin : sink_hold
    hold_long = 1'b0;
    while (results_seen < HOLD_AT) @(posedge clk);
    hold_long <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_long <= 1'b0;
  end

  initial begin : stimulus
    int              n, pick, beats;
    logic [5:0]      idx;
    logic [31:0]     xv;
    longint          mid;
    logic [PC_W-1:0] phase_counts [PHASES];
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = REQ_LOAD;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    idle_on    = 1'b1;
    count_reg  = 7'd2;
    cycle_cnt  = 0;
    beats_sent = 0;
    results_seen = 0;
    mismatches = 0;
    cfg_writes = 0;
    n_loads    = 0;
    n_queries  = 0;
    status_seen = '{0, 0, 0, 0};
    foreach (bp_x[i]) begin
      bp_x[i] = '0;
      bp_y[i] = '0;
    end
    phase_counts = '{7'd64, 7'd127, 7'd1, 7'd0, 7'd65, 7'd3, 7'd37, 7'd2, 7'd0, 7'd64};
    phase_counts[8] = 7'($urandom_range(4, 63));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows run with the point count left at its reset value
    foreach (directed[i])
      send_beat(directed[i].req, directed[i].idx, directed[i].xv, directed[i].yv,
                directed[i].typed, {directed[i].ey, directed[i].est});

    for (int ph = 0; ph < PHASES; ph++) begin
      set_point_count(phase_counts[ph]);
      idle_on = $urandom_range(0, 3) != 0;
      beats   = PHASE_BEATS;
      // a fresh table first, so that every entry a query may read is written
      if (ph % 3 == 0) begin
        load_breakpoints();
        beats -= TABLE_DEPTH;
      end
      n = active_points();
      for (int k = 0; k < beats; k++) begin
        if ($urandom_range(0, 9) < 2) begin
          idx = 6'($urandom_range(0, TABLE_DEPTH - 1));
          xv  = $urandom_range(0, 1) ? $urandom : bp_x[idx] + $urandom_range(0, 255) - 128;
          send_beat(REQ_LOAD, idx, xv, $urandom, 1'b0, '0);
        end else begin
          pick = $urandom_range(0, n - 1);
          case ($urandom_range(0, 4))
            0: xv = bp_x[pick];
            1: xv = bp_x[pick] + $urandom_range(0, 6) - 3;
            2: begin
              if (pick < n - 1) begin
                mid = (longint'(bp_x[pick]) + longint'(bp_x[pick+1])) / 2;
                xv  = mid[31:0];
              end else begin
                xv = bp_x[pick] + $urandom;
              end
            end
            3: xv = $urandom;
            default: xv = bp_x[pick] + $urandom_range(0, 1 << 16);
          endcase
          send_beat(REQ_QUERY, 6'($urandom), xv, $urandom, 1'b0, '0);
        end
      end
    end

    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d beats (%0d loads, %0d queries); %0d results checked, %0d clipped, %0d flat.",
             beats_sent, n_loads, n_queries, results_seen, status_seen[ST_SAT],
             status_seen[ST_ZSPAN]);
    $display("Point count: reset value and %0d writes from 0 to 127; %0d mismatches.",
             cfg_writes, mismatches);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("piecewise_linear_interpolator: match");
    end else begin
      $display("piecewise_linear_interpolator: mismatch");
    end
    $finish;
  end

endmodule
